// ===== design/gcsf_pkg.sv =====
// Shared types, constants and helpers for the greedy common-subsequence filter.
package gcsf_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int VAL_W       = 11;
    localparam int FUNC_W      = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PROC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [VAL_W-1:0]  position;
        logic              present;
        logic [VAL_W-1:0]  item_value;
    } t_cmd;

    typedef struct packed {
        logic             kept;
        logic [VAL_W-1:0] value_out;
        logic             error;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } t_state;

    // Positions count from one; the map stores position p at entry p - 1.
    function automatic logic [ADDR_W-1:0] pos_to_addr(input logic [VAL_W-1:0] p);
        logic [VAL_W-1:0] d;
        d = p - 1'b1;
        return ADDR_W'(d);
    endfunction

endpackage

// ===== design/gcsf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module gcsf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/gcsf_ctrl.sv =====
// Sequencer: clearing pass, command decode, cursor scan and result register.
module gcsf_ctrl import gcsf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  t_cmd             i_cmd,
    input  logic [VAL_W-1:0] i_entry_count,
    input  logic             i_rdata,
    output logic             o_busy,
    output t_mem_req         o_mem,
    output logic             o_result_valid,
    output t_result          o_result
);

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [VAL_W-1:0]  r_cursor, n_cursor;
    logic              r_error, n_error;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_res_valid, n_res_valid;
    t_result           r_res, n_res;

    logic [VAL_W-1:0]  cnt;
    logic              cur_live;
    logic              accept;

    // Counts above the map size behave as the map size.
    assign cnt = (i_entry_count > MAX_ENTRIES) ? VAL_W'(MAX_ENTRIES) : i_entry_count;
    assign cur_live = (r_cursor <= cnt);
    assign accept = start && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cursor    <= VAL_W'(1);
            r_error     <= 1'b0;
            r_clr_addr  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_error     <= n_error;
            r_clr_addr  <= n_clr_addr;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_res <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_cursor    = r_cursor;
        n_error     = r_error;
        n_clr_addr  = r_clr_addr;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_mem.we    = 1'b0;
        o_mem.waddr = '0;
        o_mem.wdata = 1'b0;
        o_mem.raddr = '0;

        case (r_state)
            ST_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr_addr;
                o_mem.wdata = 1'b0;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(MAX_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_cmd = i_cmd;
                    case (i_cmd.func)
                        FUNC_LOAD: begin
                            if (i_cmd.position >= VAL_W'(1) &&
                                i_cmd.position <= MAX_ENTRIES) begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = pos_to_addr(i_cmd.position);
                                o_mem.wdata = !i_cmd.present;
                            end
                            n_error         = 1'b0;
                            n_cursor        = VAL_W'(1);
                            n_res_valid     = 1'b1;
                            n_res.kept      = i_cmd.position >= VAL_W'(1) &&
                                              i_cmd.position <= cnt && i_cmd.present;
                            n_res.value_out = n_res.kept ? i_cmd.position : '0;
                            n_res.error     = 1'b0;
                        end
                        FUNC_PROC: begin
                            o_mem.raddr = pos_to_addr(r_cursor);
                            n_state     = ST_SCAN;
                        end
                        FUNC_READ: begin
                            o_mem.raddr = pos_to_addr(i_cmd.position);
                            n_state     = ST_READ;
                        end
                        default: begin
                            n_res_valid     = 1'b1;
                            n_res.kept      = 1'b0;
                            n_res.value_out = '0;
                            n_res.error     = r_error;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_res_valid     = 1'b1;
                n_res.kept      = r_cmd.position >= VAL_W'(1) &&
                                  r_cmd.position <= cnt && !i_rdata;
                n_res.value_out = n_res.kept ? r_cmd.position : '0;
                n_res.error     = r_error;
                n_state         = ST_IDLE;
            end
            ST_SCAN: begin
                if (cur_live && i_rdata) begin
                    // Skip a removed position and fetch the next one.
                    n_cursor    = r_cursor + 1'b1;
                    o_mem.raddr = pos_to_addr(n_cursor);
                end else begin
                    n_res.kept      = 1'b0;
                    n_res.value_out = '0;
                    if (!cur_live) begin
                        n_res.value_out = r_cmd.item_value;
                    end else if (r_cmd.item_value == '0) begin
                        n_res.value_out = '0;
                    end else if (r_cmd.item_value == r_cursor) begin
                        n_res.kept      = 1'b1;
                        n_res.value_out = r_cmd.item_value;
                        n_cursor        = r_cursor + 1'b1;
                    end else if (r_cmd.item_value > cnt) begin
                        n_error = 1'b1;
                    end else begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = pos_to_addr(r_cmd.item_value);
                        o_mem.wdata = 1'b1;
                    end
                    n_res.error = n_error;
                    n_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

// ===== design/greedy_common_subsequence_filter.sv =====
// Top level of the greedy common-subsequence filter: register, map memory and sequencer.
//
// The first sequence is the identity 1..entry_count, held as a one-bit map of
// removed positions in a single synchronous RAM of MAX_ENTRIES entries. A
// command word is taken on a clock edge where start is high and busy is low;
// its result word appears on o_result for exactly one cycle, marked by
// o_result_valid, in the cycle after the command finishes, and the receiver
// cannot hold it off. A load word (and an unused function code) does not
// make the block busy: busy stays low and the next word may follow at once.
// A read word holds busy high while the map is read. A process word holds
// busy high for one more read of the map for every removed position the
// cursor steps over, since each step is a read of the map through its one
// read port; each position is stepped over at most once between loads.
// After reset the map is cleared one entry a cycle, and busy stays high
// until all MAX_ENTRIES (1024) entries are cleared. The entry_count
// register is written through i_cfg_we and i_cfg_wdata and must only be
// changed while the block is idle.
module greedy_common_subsequence_filter import gcsf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_cmd             i_cmd,
    input  logic             i_cfg_we,
    input  logic [VAL_W-1:0] i_cfg_wdata,
    output logic             o_result_valid,
    output t_result          o_result
);

    logic [VAL_W-1:0] r_entry_count, n_entry_count;
    t_mem_req         mem_req;
    logic             map_rdata;

    // The one configuration register: the length of the first sequence.
    assign n_entry_count = i_cfg_we ? i_cfg_wdata : r_entry_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else begin
            r_entry_count <= n_entry_count;
        end
    end

    // Removed-position map; a set bit means the position has been removed.
    gcsf_ram #(
        .WIDTH (1),
        .DEPTH (MAX_ENTRIES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (map_rdata)
    );

    // Sequencer: owns the cursor, the sticky error flag and the result word.
    gcsf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_cmd          (i_cmd),
        .i_entry_count  (r_entry_count),
        .i_rdata        (map_rdata),
        .o_busy         (busy),
        .o_mem          (mem_req),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

`ifndef SYNTHESIS
    // A load word answers in the next cycle with the error flag cleared.
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.func == FUNC_LOAD) |=> (o_result_valid && !o_result.error))
        else $error("load word did not give a result with the error flag cleared");

    // A read word holds the block busy while the map is read and then answers.
    a_read_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.func == FUNC_READ) |=> busy ##1 o_result_valid)
        else $error("read word did not answer two cycles after it was taken");

    // Reset starts the clearing pass, during which no word is taken.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("block not busy after reset while the map is being cleared");

    // A kept word always carries a nonzero value.
    a_kept_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.kept) |-> (o_result.value_out != '0))
        else $error("kept result word with a zero value");
`endif

endmodule

// ===== test/gcsf_checker.sv =====
// Checker for the filter: keeps its own copy of the map, predicts each result word and compares.
module gcsf_checker import gcsf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  t_cmd             i_cmd,
    input  logic             i_cfg_we,
    input  logic [VAL_W-1:0] i_cfg_wdata,
    input  logic             i_result_valid,
    input  t_result          i_result,
    output int               o_mismatches,
    output int               o_outstanding
);

    bit               removed_pos [1:MAX_ENTRIES];
    int unsigned      cursor_pos;
    bit               error_flag;
    logic [VAL_W-1:0] count_reg;
    int               fail_tally;
    t_result          awaited_words [$];

    function automatic int unsigned live_count();
        return (count_reg > MAX_ENTRIES) ? MAX_ENTRIES : count_reg;
    endfunction

    function automatic t_result map_report(input logic [VAL_W-1:0] pos);
        t_result r;
        r = '0;
        if (pos >= 1 && pos <= live_count() && !removed_pos[pos]) begin
            r.kept      = 1'b1;
            r.value_out = pos;
        end
        return r;
    endfunction

    // Works out the result word of one command and updates the shadow state.
    function automatic t_result filter_word(input t_cmd w);
        t_result     r;
        int unsigned n;
        r = '0;
        n = live_count();
        case (w.func)
            FUNC_LOAD: begin
                if (w.position >= 1 && w.position <= MAX_ENTRIES)
                    removed_pos[w.position] = !w.present;
                error_flag = 1'b0;
                cursor_pos = 1;
                r = map_report(w.position);
            end
            FUNC_PROC: begin
                while (cursor_pos <= n && removed_pos[cursor_pos])
                    cursor_pos++;
                if (cursor_pos > n) begin
                    r.value_out = w.item_value;
                end else if (w.item_value == 0) begin
                    // An element already removed passes as zero.
                end else if (w.item_value == cursor_pos) begin
                    r.kept      = 1'b1;
                    r.value_out = w.item_value;
                    cursor_pos++;
                end else if (w.item_value > n) begin
                    error_flag = 1'b1;
                end else begin
                    removed_pos[w.item_value] = 1'b1;
                end
            end
            FUNC_READ: begin
                r = map_report(w.position);
            end
            default: begin
            end
        endcase
        r.error = error_flag;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            removed_pos = '{default: 1'b0};
            cursor_pos  = 1;
            error_flag  = 1'b0;
            count_reg   = '0;
            awaited_words.delete();
        end else begin
            if (i_cfg_we)
                count_reg = i_cfg_wdata;
            // Results are compared before the new command is queued, as a word
            // can never produce its result on the edge that accepts it.
            if (i_result_valid) begin
                if (awaited_words.size() == 0) begin
                    $error("result word %h arrived with nothing awaited", i_result);
                    fail_tally++;
                end else begin
                    want = awaited_words.pop_front();
                    if (i_result.kept !== want.kept) begin
                        $error("kept: expected %0d, got %0d", want.kept, i_result.kept);
                        fail_tally++;
                    end
                    if (i_result.value_out !== want.value_out) begin
                        $error("value_out: expected %0d, got %0d",
                               want.value_out, i_result.value_out);
                        fail_tally++;
                    end
                    if (i_result.error !== want.error) begin
                        $error("error: expected %0d, got %0d", want.error, i_result.error);
                        fail_tally++;
                    end
                end
            end
            if (start && !busy)
                awaited_words.insert(awaited_words.size(), filter_word(i_cmd));
        end
        o_outstanding <= awaited_words.size();
        o_mismatches  <= fail_tally;
    end

endmodule

// ===== test/testbench.sv =====
// Top of the filter testbench: clock, reset, command stimulus and the final verdict.
module testbench;
    import gcsf_pkg::*;

    // The package names three function codes; the fourth does nothing.
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int WORD_TARGET   = 1350;
    localparam int QUIET_WORDS   = 200;
    localparam int SETTLE_CYCLES = 8;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    t_cmd             i_cmd       = '0;
    logic             i_cfg_we    = 1'b0;
    logic [VAL_W-1:0] i_cfg_wdata = '0;
    logic             busy;
    logic             o_result_valid;
    t_result          o_result;

    int          mismatches;
    int          outstanding;
    int          words_sent;
    int          settings_used;
    int          func_tally [4];
    bit          quiet_tail;
    int unsigned live_n;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    greedy_common_subsequence_filter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    gcsf_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    function automatic t_cmd word_of(input logic [FUNC_W-1:0] f, input int unsigned pos,
                                     input bit pres, input int unsigned val);
        t_cmd w;
        w.func       = f;
        w.position   = VAL_W'(pos);
        w.present    = pres;
        w.item_value = VAL_W'(val);
        return w;
    endfunction

    // Lowers start and lets a few cycles pass; the next word raises it again on a
    // later edge, so start never sees two assignments in one step.
    task automatic hold_off(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Presents one command word and holds it until the block takes it. Start is
    // left high so that back-to-back words go through without a gap.
    task automatic put_word(input t_cmd w);
        start <= 1'b1;
        i_cmd <= w;
        do @(posedge i_clk); while (busy);
        words_sent++;
        func_tally[w.func]++;
        if (!quiet_tail && $urandom_range(0, 9) == 0)
            hold_off($urandom_range(1, 15));
    endtask

    // Waits until every predicted word has come back and the block is idle,
    // then lets the latency of a stray scan run out.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The count register only changes while the block is idle.
    task automatic set_count(input int unsigned n);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= VAL_W'(n);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
        live_n = (n > MAX_ENTRIES) ? MAX_ENTRIES : n;
    endtask

    initial begin
        int unsigned n;
        int unsigned len;
        int unsigned k;
        int unsigned r;
        int unsigned v;
        int          scenario;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. With a count of zero the first sequence is used up from
        // the start, so a process word passes straight through.
        set_count(0);
        put_word(word_of(FUNC_PROC, 0, 1'b0, 5));
        put_word(word_of(FUNC_READ, 1, 1'b0, 0));
        put_word(word_of(FUNC_NONE, 2047, 1'b1, 2047));

        // A short first sequence with one removed position and loads that fall
        // outside the map or outside the count.
        set_count(4);
        put_word(word_of(FUNC_LOAD, 1, 1'b1, 0));
        put_word(word_of(FUNC_LOAD, 2, 1'b0, 0));
        put_word(word_of(FUNC_LOAD, 0, 1'b0, 0));
        put_word(word_of(FUNC_LOAD, 2047, 1'b0, 0));
        put_word(word_of(FUNC_LOAD, MAX_ENTRIES, 1'b0, 0));
        // Zero element, a match, a mismatch that removes its own position, two
        // elements beyond the count, a match after a skip, then the used-up case.
        put_word(word_of(FUNC_PROC, 0, 1'b0, 0));
        put_word(word_of(FUNC_PROC, 0, 1'b0, 1));
        put_word(word_of(FUNC_PROC, 0, 1'b0, 4));
        put_word(word_of(FUNC_PROC, 0, 1'b0, 9));
        put_word(word_of(FUNC_PROC, 0, 1'b0, 2047));
        put_word(word_of(FUNC_PROC, 0, 1'b0, 3));
        put_word(word_of(FUNC_PROC, 0, 1'b0, 7));
        for (int p = 1; p <= 4; p++)
            put_word(word_of(FUNC_READ, p, 1'b0, 0));
        put_word(word_of(FUNC_READ, 0, 1'b0, 0));
        put_word(word_of(FUNC_READ, 2047, 1'b0, 0));
        put_word(word_of(FUNC_READ, MAX_ENTRIES, 1'b0, 0));
        put_word(word_of(FUNC_NONE, 0, 1'b0, 0));
        // A load clears the sticky error and rewinds the cursor.
        put_word(word_of(FUNC_LOAD, 3, 1'b1, 0));
        put_word(word_of(FUNC_PROC, 0, 1'b0, 1));

        // Random part: each round sets a count, loads the map, streams a second
        // sequence that mostly follows the cursor, and reads the map back.
        scenario = 0;
        while (words_sent < WORD_TARGET) begin
            quiet_tail = (words_sent > WORD_TARGET - QUIET_WORDS);
            r = $urandom_range(0, 99);
            case (scenario)
                0: n = 1;
                1: n = MAX_ENTRIES;
                2: n = 2047;
                3: n = 0;
                default: begin
                    if (r < 65)
                        n = $urandom_range(1, 12);
                    else if (r < 85)
                        n = $urandom_range(13, 64);
                    else if (r < 90)
                        n = $urandom_range(0, 1);
                    else if (r < 95)
                        n = $urandom_range(0, 2047);
                    else
                        n = ($urandom_range(0, 1) != 0) ? MAX_ENTRIES : 2047;
                end
            endcase
            scenario++;
            set_count(n);

            // Small maps are loaded whole; large ones only at a few positions.
            if (live_n <= 64) begin
                for (int p = 1; p <= live_n; p++)
                    put_word(word_of(FUNC_LOAD, p, $urandom_range(0, 4) != 0,
                                     $urandom_range(0, 2047)));
            end else begin
                repeat (16)
                    put_word(word_of(FUNC_LOAD, $urandom_range(1, live_n),
                                     $urandom_range(0, 3) != 0, $urandom_range(0, 2047)));
            end

            // The stream walks k upwards so that most elements meet the cursor;
            // the rest are jumps ahead, zeros, stray values, out-of-range values
            // and the odd word of another kind thrown in as noise.
            k   = 1;
            len = ((live_n <= 64) ? live_n : 24) + $urandom_range(0, 4);
            repeat (len) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    v = k;
                    k++;
                end else if (r < 65) begin
                    v = k + $urandom_range(1, 3);
                end else if (r < 73) begin
                    v = 0;
                end else if (r < 83) begin
                    v = $urandom_range(1, (live_n > 0) ? live_n : 1);
                end else if (r < 88) begin
                    v = live_n + $urandom_range(1, 8);
                end else begin
                    v = $urandom_range(0, 2047);
                end
                if (r >= 96)
                    put_word(word_of(FUNC_NONE, $urandom_range(0, 2047),
                                     $urandom_range(0, 1) != 0, v));
                else if (r >= 94)
                    put_word(word_of(FUNC_LOAD, $urandom_range(0, 2047),
                                     $urandom_range(0, 1) != 0, v));
                else
                    put_word(word_of(FUNC_PROC, $urandom_range(0, 2047),
                                     $urandom_range(0, 1) != 0, v));
            end

            // Read the map back, plus positions outside the count.
            if (live_n <= 64) begin
                for (int p = 1; p <= live_n; p++)
                    put_word(word_of(FUNC_READ, p, $urandom_range(0, 1) != 0,
                                     $urandom_range(0, 2047)));
            end else begin
                put_word(word_of(FUNC_READ, 1, 1'b0, 0));
                put_word(word_of(FUNC_READ, live_n, 1'b0, 0));
                repeat (16)
                    put_word(word_of(FUNC_READ, $urandom_range(1, live_n),
                                     $urandom_range(0, 1) != 0, $urandom_range(0, 2047)));
            end
            repeat (2)
                put_word(word_of(FUNC_READ, $urandom_range(0, 2047),
                                 $urandom_range(0, 1) != 0, $urandom_range(0, 2047)));
        end

        drain();
        $display("Run covered %0d command words under %0d count settings (%0d loads,",
                 words_sent, settings_used, func_tally[FUNC_LOAD]);
        $display("%0d process, %0d reads, %0d unused codes); %0d field mismatches seen.",
                 func_tally[FUNC_PROC], func_tally[FUNC_READ], func_tally[FUNC_NONE],
                 mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even if every process word
    // had to step over the whole map, plus the map clear.
    initial begin
        #(12 * 10_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/gcsf_pkg.sv
design/gcsf_ram.sv
design/gcsf_ctrl.sv
design/greedy_common_subsequence_filter.sv
test/gcsf_checker.sv
test/testbench.sv
